// File: hdl/psf_pkg.sv
// shared widths, register codes and reset values for the spring force block
// no dependencies; used by psf_div_cell, the top level and the testbench
`timescale 1ns / 1ps

package psf_pkg;

    localparam int AXES          = 3;
    localparam int COORD_W       = 32;
    localparam int DIFF_W        = 33;
    localparam int MAG_W         = 33;
    localparam int SQ_W          = 66;
    localparam int SQRT_W        = 33;
    localparam int K_W           = 32;
    localparam int REST_W        = 31;
    localparam int EXT_W         = 33;
    localparam int KM_W          = 65;
    localparam int KM_LO_W       = 33;
    localparam int NUM_W         = 98;
    localparam int QUO_W         = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic REG_STIFFNESS = 1'b0;
    localparam logic REG_REST      = 1'b1;

    localparam logic [K_W-1:0]    K_RESET    = 32'h0001_0000;
    localparam logic [REST_W-1:0] REST_RESET = '0;

endpackage

// File: hdl/psf_sqrt_cell.sv
// one digit step of the pipelined integer square root
// depends on nothing but its parameter
`timescale 1ns / 1ps

module psf_sqrt_cell #(
    parameter int ROOT_W = 33
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [ROOT_W+1:0]     in_rem,
    input  logic [ROOT_W-1:0]     in_root,
    input  logic [2*ROOT_W-1:0]   in_rad,
    output logic                  out_valid,
    output logic [ROOT_W+1:0]     out_rem,
    output logic [ROOT_W-1:0]     out_root,
    output logic [2*ROOT_W-1:0]   out_rad
);

    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic                fits;
    logic [ROOT_W+1:0]   rem_next;
    logic [ROOT_W-1:0]   root_next;
    logic [2*ROOT_W-1:0] rad_next;
    logic                valid_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [2*ROOT_W-1:0] rad_reg;

    // bring down the next two radicand bits
    assign rem_sh    = {in_rem[ROOT_W-1:0], in_rad[2*ROOT_W-1 -: 2]};
    assign trial     = {in_root, 2'b01};
    assign fits      = (rem_sh >= trial);
    assign rem_next  = fits ? (rem_sh - trial) : rem_sh;
    assign root_next = {in_root[ROOT_W-2:0], fits};
    assign rad_next  = {in_rad[2*ROOT_W-3:0], 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;

endmodule

// File: hdl/psf_div_cell.sv
// one quotient bit of the three-lane restoring divider
// depends on psf_pkg for the lane count and quotient width
`timescale 1ns / 1ps

module psf_div_cell #(
    parameter int DEN_W = 49
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    input  logic [DEN_W-1:0]                             in_den,
    input  logic [psf_pkg::AXES-1:0][DEN_W:0]            in_rem,
    input  logic [psf_pkg::AXES-1:0][psf_pkg::QUO_W-1:0] in_acc,
    output logic                                         out_valid,
    output logic [DEN_W-1:0]                             out_den,
    output logic [psf_pkg::AXES-1:0][DEN_W:0]            out_rem,
    output logic [psf_pkg::AXES-1:0][psf_pkg::QUO_W-1:0] out_acc
);

    logic [psf_pkg::AXES-1:0][DEN_W:0]            rem_next;
    logic [psf_pkg::AXES-1:0][psf_pkg::QUO_W-1:0] acc_next;
    logic                                         valid_reg;
    logic [DEN_W-1:0]                             den_reg;
    logic [psf_pkg::AXES-1:0][DEN_W:0]            rem_reg;
    logic [psf_pkg::AXES-1:0][psf_pkg::QUO_W-1:0] acc_reg;

    // remainder stays below the divisor, so the shifted value fits one extra bit
    always_comb
    begin
        logic [DEN_W:0] rem_sh;
        logic           fits;
        for (int a = 0; a < psf_pkg::AXES; a++)
        begin
            rem_sh      = {in_rem[a][DEN_W-1:0], in_acc[a][psf_pkg::QUO_W-1]};
            fits        = (rem_sh >= {1'b0, in_den});
            rem_next[a] = fits ? (rem_sh - {1'b0, in_den}) : rem_sh;
            acc_next[a] = {in_acc[a][psf_pkg::QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= in_den;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;

endmodule

// File: hdl/particle_spring_force.sv
// top level of the spring / bungee force pipeline with its register port
// depends on psf_pkg, psf_sqrt_cell and psf_div_cell
`timescale 1ns / 1ps

// fully pipelined: busy never rises, so a new request transfer can be made in
// every cycle, and each request yields exactly one result strobe (done). the
// pipe is made of the 33-cell square root chain (one root bit per cell), the
// 32-cell divider chain (one quotient bit per cell, three axes side by side),
// and eight stages for difference, squares, sum, extension times stiffness,
// two partial product steps, overflow test and output clamp. results cannot
// be held off: the receiver must take each one in the cycle it is shown. the
// stiffness and rest length registers are read by stage 4, deep in the pipe,
// so write them only while no request is in flight.

module particle_spring_force #(
    parameter int FRAC_BITS = psf_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psf_pkg::ADDR_W-1:0]   paddr,
    input  logic [psf_pkg::DATA_W-1:0]   pwdata,
    output logic [psf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // request
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic signed [psf_pkg::COORD_W-1:0] pos_x,
    input  logic signed [psf_pkg::COORD_W-1:0] pos_y,
    input  logic signed [psf_pkg::COORD_W-1:0] pos_z,
    input  logic signed [psf_pkg::COORD_W-1:0] end_x,
    input  logic signed [psf_pkg::COORD_W-1:0] end_y,
    input  logic signed [psf_pkg::COORD_W-1:0] end_z,
    // result
    output logic                         done,
    output logic signed [psf_pkg::COORD_W-1:0] force_x,
    output logic signed [psf_pkg::COORD_W-1:0] force_y,
    output logic signed [psf_pkg::COORD_W-1:0] force_z,
    output logic                         force_applied,
    output logic                         saturated
);

    localparam int AXES    = psf_pkg::AXES;
    localparam int MAG_W   = psf_pkg::MAG_W;
    localparam int SQRT_W  = psf_pkg::SQRT_W;
    localparam int QUO_W   = psf_pkg::QUO_W;
    localparam int NUM_W   = psf_pkg::NUM_W;
    localparam int KM_W    = psf_pkg::KM_W;
    localparam int KM_LO_W = psf_pkg::KM_LO_W;
    localparam int DEN_W   = SQRT_W + FRAC_BITS;
    localparam int HI_W    = NUM_W - QUO_W;
    localparam int LATENCY = 8 + SQRT_W + QUO_W;

    // side data riding along the square root chain
    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [AXES-1:0]            dpos;
        logic                       bungee;
    } sq_side_t;

    // side data riding along the divider chain
    typedef struct packed {
        logic [AXES-1:0] dpos;
        logic [AXES-1:0] skip;
        logic [AXES-1:0] ovf;
        logic            slack;
    } div_side_t;

    //------------------------------------------------------------------
    // configuration registers
    //------------------------------------------------------------------
    logic [psf_pkg::K_W-1:0]    stiff_reg;
    logic [psf_pkg::REST_W-1:0] rest_reg;
    logic                       cfg_wr;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_sel = paddr[psf_pkg::ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= psf_pkg::K_RESET;
            rest_reg  <= psf_pkg::REST_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                psf_pkg::REG_STIFFNESS: stiff_reg <= pwdata;
                psf_pkg::REG_REST:      rest_reg  <= pwdata[psf_pkg::REST_W-1:0];
                default:                stiff_reg <= stiff_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            psf_pkg::REG_STIFFNESS: prdata = stiff_reg;
            psf_pkg::REG_REST:      prdata = {1'b0, rest_reg};
            default:                prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // stage 1: differences and magnitudes
    //------------------------------------------------------------------
    logic                      accept;
    logic [AXES-1:0][psf_pkg::COORD_W-1:0] pos_a;
    logic [AXES-1:0][psf_pkg::COORD_W-1:0] end_a;
    logic [AXES-1:0][MAG_W-1:0] mag_next;
    logic [AXES-1:0]            dpos_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign pos_a  = {pos_z, pos_y, pos_x};
    assign end_a  = {end_z, end_y, end_x};

    always_comb
    begin
        logic [psf_pkg::DIFF_W-1:0] diff;
        for (int a = 0; a < AXES; a++)
        begin
            diff = {pos_a[a][psf_pkg::COORD_W-1], pos_a[a]}
                 - {end_a[a][psf_pkg::COORD_W-1], end_a[a]};
            mag_next[a]  = diff[psf_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
            // force points against d, so a positive d gives a negative force
            dpos_next[a] = ~diff[psf_pkg::DIFF_W-1] & (diff != '0);
        end
    end

    logic     s1_valid_reg;
    sq_side_t s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg.mag    <= mag_next;
        s1_side_reg.dpos   <= dpos_next;
        s1_side_reg.bungee <= req_type;
    end

    //------------------------------------------------------------------
    // stage 2: squares, stage 3: sum of squares
    //------------------------------------------------------------------
    logic                             s2_valid_reg;
    sq_side_t                         s2_side_reg;
    logic [AXES-1:0][psf_pkg::SQ_W-1:0] s2_sq_reg;
    logic                             s3_valid_reg;
    sq_side_t                         s3_side_reg;
    logic [psf_pkg::SQ_W-1:0]         s3_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            s2_sq_reg[a] <= s1_side_reg.mag[a] * s1_side_reg.mag[a];
        end
        s2_side_reg <= s1_side_reg;
        // three squares below 2^64 each, so the sum fits 66 bits
        s3_sum_reg  <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        s3_side_reg <= s2_side_reg;
    end

    //------------------------------------------------------------------
    // square root chain: one root bit per cell
    //------------------------------------------------------------------
    logic [SQRT_W:0]                 sq_valid;
    logic [SQRT_W:0][SQRT_W+1:0]     sq_rem;
    logic [SQRT_W:0][SQRT_W-1:0]     sq_root;
    logic [SQRT_W:0][2*SQRT_W-1:0]   sq_rad;
    sq_side_t                        sq_side_reg [SQRT_W];

    assign sq_valid[0] = s3_valid_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = s3_sum_reg;

    for (genvar c = 0; c < SQRT_W; c++)
    begin : g_sqrt
        psf_sqrt_cell #(
            .ROOT_W (SQRT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[c]),
            .in_rem    (sq_rem[c]),
            .in_root   (sq_root[c]),
            .in_rad    (sq_rad[c]),
            .out_valid (sq_valid[c+1]),
            .out_rem   (sq_rem[c+1]),
            .out_root  (sq_root[c+1]),
            .out_rad   (sq_rad[c+1])
        );
    end

    always_ff @(posedge clk)
    begin
        sq_side_reg[0] <= s3_side_reg;
        for (int c = 1; c < SQRT_W; c++)
        begin
            sq_side_reg[c] <= sq_side_reg[c-1];
        end
    end

    //------------------------------------------------------------------
    // stage 4: extension, slack test, stiffness times extension
    //------------------------------------------------------------------
    logic [SQRT_W-1:0]        len;
    sq_side_t                 len_side;
    logic [psf_pkg::EXT_W-1:0] rest_ext;
    logic [psf_pkg::EXT_W-1:0] ext;
    logic                     slack_next;

    assign len        = sq_root[SQRT_W];
    assign len_side   = sq_side_reg[SQRT_W-1];
    assign rest_ext   = {{(psf_pkg::EXT_W-psf_pkg::REST_W){1'b0}}, rest_reg};
    assign ext        = (len >= rest_ext) ? (len - rest_ext) : (rest_ext - len);
    assign slack_next = len_side.bungee & (len < rest_ext);

    logic                       s4_valid_reg;
    logic [KM_W-1:0]            s4_km_reg;
    logic [DEN_W-1:0]           s4_den_reg;
    logic [AXES-1:0][MAG_W-1:0] s4_mag_reg;
    logic [AXES-1:0]            s4_dpos_reg;
    logic                       s4_slack_reg;

    //------------------------------------------------------------------
    // stage 5: partial products, stage 6: full numerators
    //------------------------------------------------------------------
    logic                                    s5_valid_reg;
    logic [AXES-1:0][KM_LO_W+MAG_W-1:0]      s5_plo_reg;
    logic [AXES-1:0][KM_W-KM_LO_W+MAG_W-1:0] s5_phi_reg;
    logic [DEN_W-1:0]                        s5_den_reg;
    logic [AXES-1:0][MAG_W-1:0]              s5_mag_reg;
    logic [AXES-1:0]                         s5_dpos_reg;
    logic                                    s5_slack_reg;

    logic                       s6_valid_reg;
    logic [AXES-1:0][NUM_W-1:0] s6_num_reg;
    logic [DEN_W-1:0]           s6_den_reg;
    logic [AXES-1:0]            s6_skip_reg;
    logic [AXES-1:0]            s6_dpos_reg;
    logic                       s6_slack_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= sq_valid[SQRT_W];
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_km_reg    <= stiff_reg * ext;
        s4_den_reg   <= {len, {FRAC_BITS{1'b0}}};
        s4_mag_reg   <= len_side.mag;
        s4_dpos_reg  <= len_side.dpos;
        s4_slack_reg <= slack_next;

        for (int a = 0; a < AXES; a++)
        begin
            s5_plo_reg[a] <= s4_km_reg[KM_LO_W-1:0] * s4_mag_reg[a];
            s5_phi_reg[a] <= s4_km_reg[KM_W-1:KM_LO_W] * s4_mag_reg[a];
        end
        s5_den_reg   <= s4_den_reg;
        s5_mag_reg   <= s4_mag_reg;
        s5_dpos_reg  <= s4_dpos_reg;
        s5_slack_reg <= s4_slack_reg;

        for (int a = 0; a < AXES; a++)
        begin
            s6_num_reg[a]  <= {s5_phi_reg[a], {KM_LO_W{1'b0}}}
                            + {{(NUM_W-KM_LO_W-MAG_W){1'b0}}, s5_plo_reg[a]};
            // a zero component (and a zero length) gives no force at all
            s6_skip_reg[a] <= (s5_mag_reg[a] == '0);
        end
        s6_den_reg   <= s5_den_reg;
        s6_dpos_reg  <= s5_dpos_reg;
        s6_slack_reg <= s5_slack_reg;
    end

    //------------------------------------------------------------------
    // stage 7: overflow test and divider seed
    //------------------------------------------------------------------
    // the quotient fits 32 bits exactly when the upper part of the
    // numerator is below the divisor; that part then seeds the remainder
    logic [AXES-1:0]            ovf_next;
    logic [AXES-1:0][DEN_W:0]   rem_seed;
    logic [AXES-1:0][QUO_W-1:0] acc_seed;

    always_comb
    begin
        logic [HI_W-1:0] hi;
        for (int a = 0; a < AXES; a++)
        begin
            hi          = s6_num_reg[a][NUM_W-1:QUO_W];
            ovf_next[a] = (hi >= {{(HI_W-DEN_W){1'b0}}, s6_den_reg});
            rem_seed[a] = ovf_next[a] ? '0 : hi[DEN_W:0];
            acc_seed[a] = s6_num_reg[a][QUO_W-1:0];
        end
    end

    logic                       s7_valid_reg;
    logic [DEN_W-1:0]           s7_den_reg;
    logic [AXES-1:0][DEN_W:0]   s7_rem_reg;
    logic [AXES-1:0][QUO_W-1:0] s7_acc_reg;
    div_side_t                  s7_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_den_reg        <= s6_den_reg;
        s7_rem_reg        <= rem_seed;
        s7_acc_reg        <= acc_seed;
        s7_side_reg.dpos  <= s6_dpos_reg;
        s7_side_reg.skip  <= s6_skip_reg;
        s7_side_reg.ovf   <= ovf_next;
        s7_side_reg.slack <= s6_slack_reg;
    end

    //------------------------------------------------------------------
    // divider chain: one quotient bit per cell, three axes per cell
    //------------------------------------------------------------------
    logic [QUO_W:0]                        dv_valid;
    logic [QUO_W:0][DEN_W-1:0]             dv_den;
    logic [QUO_W:0][AXES-1:0][DEN_W:0]     dv_rem;
    logic [QUO_W:0][AXES-1:0][QUO_W-1:0]   dv_acc;
    div_side_t                             dv_side_reg [QUO_W];

    assign dv_valid[0] = s7_valid_reg;
    assign dv_den[0]   = s7_den_reg;
    assign dv_rem[0]   = s7_rem_reg;
    assign dv_acc[0]   = s7_acc_reg;

    for (genvar c = 0; c < QUO_W; c++)
    begin : g_div
        psf_div_cell #(
            .DEN_W (DEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[c]),
            .in_den    (dv_den[c]),
            .in_rem    (dv_rem[c]),
            .in_acc    (dv_acc[c]),
            .out_valid (dv_valid[c+1]),
            .out_den   (dv_den[c+1]),
            .out_rem   (dv_rem[c+1]),
            .out_acc   (dv_acc[c+1])
        );
    end

    always_ff @(posedge clk)
    begin
        dv_side_reg[0] <= s7_side_reg;
        for (int c = 1; c < QUO_W; c++)
        begin
            dv_side_reg[c] <= dv_side_reg[c-1];
        end
    end

    //------------------------------------------------------------------
    // output stage: sign, clamp and slack bungee
    //------------------------------------------------------------------
    div_side_t                  q_side;
    logic [AXES-1:0][QUO_W-1:0] force_next;
    logic [AXES-1:0]            clamp;

    assign q_side = dv_side_reg[QUO_W-1];

    always_comb
    begin
        logic [QUO_W-1:0] lim;
        logic [QUO_W-1:0] q;
        logic [QUO_W-1:0] qm;
        for (int a = 0; a < AXES; a++)
        begin
            lim      = q_side.dpos[a] ? {1'b1, {(QUO_W-1){1'b0}}}
                                      : {1'b0, {(QUO_W-1){1'b1}}};
            q        = dv_acc[QUO_W][a];
            clamp[a] = ~q_side.skip[a] & ~q_side.slack & (q_side.ovf[a] | (q > lim));
            qm       = clamp[a] ? lim : q;
            if (q_side.skip[a] || q_side.slack)
            begin
                force_next[a] = '0;
            end
            else if (q_side.dpos[a])
            begin
                force_next[a] = ~qm + 1'b1;
            end
            else
            begin
                force_next[a] = qm;
            end
        end
    end

    logic                       done_reg;
    logic [AXES-1:0][QUO_W-1:0] force_reg;
    logic                       applied_reg;
    logic                       sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        force_reg   <= force_next;
        applied_reg <= ~q_side.slack;
        sat_reg     <= |clamp;
    end

    assign done          = done_reg;
    assign force_x       = force_reg[0];
    assign force_y       = force_reg[1];
    assign force_z       = force_reg[2];
    assign force_applied = applied_reg;
    assign saturated     = sat_reg;

`ifndef SYNTHESIS
    // every request transfer shows up as a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after request transfer");

    // a slack bungee carries no force and no clamp
    a_slack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !force_applied) |->
            (force_x == '0 && force_y == '0 && force_z == '0 && !saturated))
        else $error("slack bungee result is not all zero");

    // clamping only happens on an applied force
    a_sat_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> force_applied)
        else $error("saturation flagged without applied force");

    // every seeded divider entry reaches the result strobe
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (s7_valid_reg) |-> ##(QUO_W + 1) done)
        else $error("divider chain lost a result");
`endif

endmodule

// File: dv/particle_spring_force_tb.sv
// self-checking testbench for the spring / bungee force pipeline
// depends on psf_pkg and particle_spring_force; runs a directed table, then random traffic
`timescale 1ns / 1ps

module particle_spring_force_tb;

    // one request: kind plus own and far-end coordinates, axis 0 = x
    typedef struct packed {
        logic              bungee;
        logic [2:0][31:0]  own;
        logic [2:0][31:0]  other;
    } pair_t;

    // one result as the block presents it
    typedef struct packed {
        logic [2:0][31:0]  frc;
        logic              applied;
        logic              sat;
    } force_t;

    // directed row: register values to run under, the pair, optional typed answer
    typedef struct packed {
        logic [31:0]  stiff;
        logic [30:0]  rest;
        pair_t        pair;
        logic         typed;
        force_t       answer;
    } row_t;

    localparam int LATENCY = 80;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [psf_pkg::ADDR_W-1:0] paddr = '0;
    logic [psf_pkg::DATA_W-1:0] pwdata = '0;
    logic [psf_pkg::DATA_W-1:0] prdata;
    logic         pready;
    logic         start = 1'b0;
    logic         busy;
    logic         req_type = 1'b0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
    logic         done;
    logic signed [31:0] force_x, force_y, force_z;
    logic         force_applied;
    logic         saturated;

    // predictor copy of the two registers
    logic [31:0]  stiff_q = psf_pkg::K_RESET;
    logic [30:0]  rest_q = psf_pkg::REST_RESET;

    force_t       pend_force = '0;   // answer riding along with the driven request
    force_t       force_q[$];        // answers waiting for their result strobe
    int unsigned  xfer_cnt = 0;
    int unsigned  err_cnt = 0;
    row_t         rows[$];

    particle_spring_force dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .req_type(req_type),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .done(done), .force_x(force_x), .force_y(force_y), .force_z(force_z),
        .force_applied(force_applied), .saturated(saturated)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hooke force with exact wide arithmetic, truncation toward zero, clamp per axis
    function automatic force_t calc_force(pair_t p);
        logic signed [32:0] dif[3];
        logic [127:0] mag[3];
        logic [127:0] sum, cand, len, ext, km, quo, lim;
        force_t r;
        r = '0;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            dif[i] = $signed({p.own[i][31], p.own[i]}) - $signed({p.other[i][31], p.other[i]});
            mag[i] = {95'b0, dif[i][32] ? 33'(-dif[i]) : 33'(dif[i])};
            sum = sum + mag[i] * mag[i];
        end
        len = '0;
        for (int b = 35; b >= 0; b--)
        begin
            cand = len | (128'd1 << b);
            if (cand * cand <= sum)
                len = cand;
        end
        // slack bungee: nothing at all
        if (p.bungee && len < {97'b0, rest_q})
            return r;
        ext = (len >= {97'b0, rest_q}) ? len - {97'b0, rest_q} : {97'b0, rest_q} - len;
        km = {96'b0, stiff_q} * ext;
        r.applied = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            // zero length gives zero force on every axis
            if (len != 0 && mag[i] != 0)
            begin
                quo = (km * mag[i]) / (len << psf_pkg::FRAC_BITS_DEF);
                lim = (dif[i] > 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
                if (quo > lim)
                begin
                    quo = lim;
                    r.sat = 1'b1;
                end
                r.frc[i] = (dif[i] > 0) ? -quo[31:0] : quo[31:0];
            end
        end
        return r;
    endfunction

    // transfer detect and result compare, both on sampled values
    always @(posedge clk)
    begin
        force_t got, want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                force_q = {force_q, pend_force};
                xfer_cnt <= xfer_cnt + 1;
            end
            if (done)
            begin
                got.frc[0] = force_x;
                got.frc[1] = force_y;
                got.frc[2] = force_z;
                got.applied = force_applied;
                got.sat = saturated;
                if (force_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result x=%h y=%h z=%h", force_x, force_y, force_z);
                end
                else
                begin
                    want = force_q.pop_front();
                    if (got !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"mismatch exp x=%h y=%h z=%h app=%b sat=%b ",
                                      "got x=%h y=%h z=%h app=%b sat=%b"},
                                     want.frc[0], want.frc[1], want.frc[2],
                                     want.applied, want.sat,
                                     got.frc[0], got.frc[1], got.frc[2],
                                     got.applied, got.sat);
                    end
                end
            end
        end
    end

    // one request transfer, optionally after a random idle gap
    task automatic send_pair(pair_t p, force_t ans, int idle_pct);
        int unsigned n;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= p.bungee;
        pos_x <= p.own[0];
        pos_y <= p.own[1];
        pos_z <= p.own[2];
        end_x <= p.other[0];
        end_y <= p.other[1];
        end_z <= p.other[2];
        pend_force <= ans;
        n = xfer_cnt;
        wait (xfer_cnt != n);
    endtask

    // let the pipe empty out before touching registers
    task automatic drain();
        start <= 1'b0;
        wait (force_q.size() == 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    // setup + access phase register write, then the port is left idle
    task automatic write_reg(logic idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == psf_pkg::REG_STIFFNESS)
            stiff_q = val;
        else
            rest_q = val[30:0];
        @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] k, logic [30:0] rst_len);
        drain();
        write_reg(psf_pkg::REG_STIFFNESS, k);
        write_reg(psf_pkg::REG_REST, {1'b0, rst_len});
    endtask

    task automatic add_row(logic [31:0] k, logic [30:0] rl, logic bg,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                           logic typed, logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                           logic app, logic st);
        row_t r;
        r.stiff = k;
        r.rest = rl;
        r.pair.bungee = bg;
        r.pair.own = {pz, py, px};
        r.pair.other = {ez, ey, ex};
        r.typed = typed;
        r.answer.frc = {fz, fy, fx};
        r.answer.applied = app;
        r.answer.sat = st;
        rows = {rows, r};
    endtask

    // random pair: mostly nearby ends so forces stay in range, some noise and extremes
    function automatic pair_t rand_pair();
        pair_t p;
        int unsigned mode;
        int unsigned sh;
        mode = $urandom_range(9);
        p.bungee = 1'($urandom_range(1));
        for (int i = 0; i < 3; i++)
        begin
            p.own[i] = $urandom;
            sh = $urandom_range(2, 20);
            if (mode < 2)
                p.other[i] = $urandom;
            else if (mode < 8)
                p.other[i] = p.own[i] + ($urandom & ((32'd1 << sh) - 1)) - (32'd1 << (sh - 1));
            else if (mode == 8)
                p.other[i] = p.own[i];
            else
            begin
                p.own[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                p.other[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
        end
        return p;
    endfunction

    initial
    begin
        logic [31:0] k;
        logic [30:0] rl;
        int idle_pct;
        force_t ans;
        // k and rest per row; typed answers where obvious
        add_row(32'h1_0000, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_row(32'h1_0000, 0, 0, 32'h1_0000, 0, 0, 0, 0, 0, 1, 32'hFFFF_0000, 0, 0, 1, 0);
        add_row(32'h1_0000, 0, 0, 0, 0, 0, 0, 32'h1_0000, 0, 1, 0, 32'h1_0000, 0, 1, 0);
        add_row(32'h1_0000, 0, 1, 32'h1_0000, 0, 0, 0, 0, 0, 1, 32'hFFFF_0000, 0, 0, 1, 0);
        add_row(32'h1_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                1, 32'h8000_0000, 0, 0, 1, 1);
        add_row(32'h1_0000, 0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
                1, 32'h7FFF_FFFF, 0, 0, 1, 1);
        add_row(32'h1_0000, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0, 0, 0);
        add_row(32'h1_0000, 0, 0, 32'h0003_0000, 32'hFFFE_8000, 32'h0000_0001,
                32'h0000_1234, 32'h0002_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        // zero stiffness: no force but applied
        add_row(32'h0, 0, 0, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0,
                1, 0, 0, 0, 1, 0);
        // slack bungee, then the same pair as a compressed spring (|e| pulls inward)
        add_row(32'h1_0000, 31'h2_0000, 1, 32'h1_0000, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(32'h1_0000, 31'h2_0000, 0, 32'h1_0000, 0, 0, 0, 0, 0,
                1, 32'hFFFF_0000, 0, 0, 1, 0);
        // bungee exactly at rest length
        add_row(32'h1_0000, 31'h2_0000, 1, 32'h2_0000, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_row(32'h1_0000, 31'h7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(32'h1_0000, 31'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_row(32'h1_0000, 31'h7FFF_FFFF, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'hFFFF_FFFF, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0,
                0, 0, 0, 0, 0, 0);
        add_row(32'hFFFF_FFFF, 0, 0, 32'h1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'hFFFF_FFFF, 0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i])
        begin
            if (rows[i].stiff != stiff_q || rows[i].rest != rest_q)
                set_regs(rows[i].stiff, rows[i].rest);
            ans = rows[i].typed ? rows[i].answer : calc_force(rows[i].pair);
            send_pair(rows[i].pair, ans, 0);
        end

        // random phases with register settings at and between the extremes
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin k = 32'h1_0000;  rl = '0;              idle_pct = 0;  end
                1: begin k = 32'hFFFF_FFFF; rl = 31'h7FFF_FFFF; idle_pct = 71; end
                2: begin k = 32'h0;       rl = 31'($urandom);   idle_pct = 0;  end
                3: begin k = $urandom_range(32'h4_0000);
                         rl = 31'($urandom_range(32'h10_0000));
                         idle_pct = 35; end
                default: begin k = $urandom; rl = 31'($urandom); idle_pct = 71; end
            endcase
            set_regs(k, rl);
            for (int n = 0; n < 230; n++)
            begin
                pair_t p;
                p = rand_pair();
                // stretches of back-to-back transfers inside idle phases too
                send_pair(p, calc_force(p), ((n / 40) % 2 == 1) ? 0 : idle_pct);
            end
        end

        drain();
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
